@@ sv/assert_macros.svh @@
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define DTL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define DTL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DTL_ASSERT(lbl, clk, rstn, prop, msg)
`define DTL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ sv/dtl_pkg.sv @@
`default_nettype none
package dtl_pkg;
    localparam int DATA_ROWS         = 35;
    localparam int TABLE_ENTRIES_DEF = 35;
    localparam int SAMPLE_BITS_DEF   = 10;
    localparam int REF_MV            = 3000;
    localparam int REF_BITS          = 12;
    localparam int MV_BITS           = 11;
    localparam int KELVIN_BITS       = 9;
    localparam int IDX_BITS          = 6;
    localparam int DK_BITS           = 7;
    localparam int Q_BITS            = 8;
    localparam int VALUE_BITS        = 12;

    typedef enum logic [2:0] {
        ST_TEMP    = 3'd0,
        ST_VOLT    = 3'd1,
        ST_INVALID = 3'd2,
        ST_OVER    = 3'd3,
        ST_UNDER   = 3'd4
    } t_status;

    typedef struct packed {
        t_status                 status;
        logic [VALUE_BITS-1:0]   value;
    } t_res;

    function automatic logic [MV_BITS-1:0] cal_mv(input logic [IDX_BITS-1:0] row);
        logic [MV_BITS-1:0] mv;
        case (row)
            6'd0:  mv = 11'd1420;
            6'd1:  mv = 11'd1214;
            6'd2:  mv = 11'd1107;
            6'd3:  mv = 11'd1088;
            6'd4:  mv = 11'd1071;
            6'd5:  mv = 11'd1053;
            6'd6:  mv = 11'd1034;
            6'd7:  mv = 11'd1015;
            6'd8:  mv = 11'd996;
            6'd9:  mv = 11'd976;
            6'd10: mv = 11'd955;
            6'd11: mv = 11'd934;
            6'd12: mv = 11'd912;
            6'd13: mv = 11'd891;
            6'd14: mv = 11'd869;
            6'd15: mv = 11'd847;
            6'd16: mv = 11'd824;
            6'd17: mv = 11'd801;
            6'd18: mv = 11'd779;
            6'd19: mv = 11'd756;
            6'd20: mv = 11'd732;
            6'd21: mv = 11'd709;
            6'd22: mv = 11'd686;
            6'd23: mv = 11'd662;
            6'd24: mv = 11'd638;
            6'd25: mv = 11'd615;
            6'd26: mv = 11'd591;
            6'd27: mv = 11'd567;
            6'd28: mv = 11'd543;
            6'd29: mv = 11'd519;
            6'd30: mv = 11'd495;
            6'd31: mv = 11'd471;
            6'd32: mv = 11'd446;
            6'd33: mv = 11'd422;
            6'd34: mv = 11'd398;
            default: mv = '0;
        endcase
        return mv;
    endfunction

    // Rows are evenly spaced by 10 K starting at 10 K.
    function automatic logic [KELVIN_BITS-1:0] cal_kelvin(input logic [IDX_BITS-1:0] row);
        logic [KELVIN_BITS-1:0] k;
        if (row < IDX_BITS'(DATA_ROWS)) begin
            k = KELVIN_BITS'(({3'd0, row} + 9'd1) * 9'd10);
        end else begin
            k = '0;
        end
        return k;
    endfunction
endpackage
`default_nettype wire

@@ sv/dtl_front.sv @@
`default_nettype none
module dtl_front import dtl_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire logic                                  i_vld,
    input  wire logic [SAMPLE_BITS-1:0]                i_code,
    input  wire logic                                  i_sample_valid,
    input  wire logic                                  i_want,
    output logic                                       o_vld,
    output t_res                                       o_res,
    output logic [MV_BITS+SAMPLE_BITS+DK_BITS+1:0]     o_num,
    output logic [MV_BITS+SAMPLE_BITS:0]               o_den2
);
    localparam int ROWS = (TABLE_ENTRIES > DATA_ROWS) ? DATA_ROWS :
                          ((TABLE_ENTRIES < 1) ? 1 : TABLE_ENTRIES);
    localparam int VB = SAMPLE_BITS + REF_BITS;
    localparam int DB = MV_BITS + SAMPLE_BITS;
    localparam int NB = DB + DK_BITS + 2;

    // Stage A: scaled sample voltage.
    logic          r_a_vld, r_a_ok, r_a_want;
    logic [VB-1:0] r_a_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_v    <= VB'(i_code) * VB'(REF_MV);
            r_a_ok   <= i_sample_valid;
            r_a_want <= i_want;
        end
    end

    // Stage B: compare against every table row at once.
    logic [ROWS-1:0]       n_b_ge;
    logic                  n_b_over;
    logic [VALUE_BITS-1:0] n_b_mv;
    logic                  r_b_vld, r_b_ok, r_b_want, r_b_over;
    logic [ROWS-1:0]       r_b_ge;
    logic [VB-1:0]         r_b_v;
    logic [VALUE_BITS-1:0] r_b_mv;

    always_comb begin
        for (int i = 0; i < ROWS; i++) begin
            n_b_ge[i] = (i != 0) &&
                        (r_a_v >= (VB'(cal_mv(IDX_BITS'(i))) << SAMPLE_BITS));
        end
        n_b_over = r_a_v > (VB'(cal_mv('0)) << SAMPLE_BITS);
        n_b_mv   = VALUE_BITS'((r_a_v + (VB'(1) << (SAMPLE_BITS - 1))) >> SAMPLE_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_ge   <= n_b_ge;
            r_b_over <= n_b_over;
            r_b_mv   <= n_b_mv;
            r_b_v    <= r_a_v;
            r_b_ok   <= r_a_ok;
            r_b_want <= r_a_want;
        end
    end

    // Stage C: pick the segment and its endpoints.
    logic [IDX_BITS-1:0]    n_c_idx;
    logic                   n_c_found;
    logic [DB-1:0]          n_c_hi, n_c_lo, n_c_den;
    logic [KELVIN_BITS-1:0] n_c_kprev, n_c_kcur;
    logic                   n_c_slope_ok;
    t_res                   n_c_res;
    logic                   r_c_vld;
    t_res                   r_c_res;
    logic [DB-1:0]          r_c_diff, r_c_den;
    logic [DK_BITS-1:0]     r_c_dk;
    logic [DK_BITS-1:0]     n_c_dk;

    always_comb begin
        n_c_idx   = '0;
        n_c_found = 1'b0;
        for (int i = ROWS - 1; i >= 1; i--) begin
            if (r_b_ge[i]) begin
                n_c_idx   = IDX_BITS'(i);
                n_c_found = 1'b1;
            end
        end
        n_c_hi       = DB'(cal_mv(n_c_idx - IDX_BITS'(1))) << SAMPLE_BITS;
        n_c_lo       = DB'(cal_mv(n_c_idx)) << SAMPLE_BITS;
        n_c_den      = n_c_hi - n_c_lo;
        n_c_kprev    = cal_kelvin(n_c_idx - IDX_BITS'(1));
        n_c_kcur     = cal_kelvin(n_c_idx);
        n_c_slope_ok = (n_c_den != '0) && (n_c_kcur >= n_c_kprev);
        n_c_dk       = n_c_slope_ok ?
                       DK_BITS'(12'(n_c_kcur - n_c_kprev) * 12'd10) : '0;

        n_c_res.value = '0;
        if (!r_b_ok) begin
            n_c_res.status = ST_INVALID;
        end else if (r_b_want) begin
            n_c_res.status = ST_VOLT;
            n_c_res.value  = r_b_mv;
        end else if (r_b_over) begin
            n_c_res.status = ST_OVER;
        end else if (!n_c_found) begin
            n_c_res.status = ST_UNDER;
        end else begin
            n_c_res.status = ST_TEMP;
            n_c_res.value  = VALUE_BITS'(n_c_kprev) * VALUE_BITS'(10);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_res  <= n_c_res;
            r_c_diff <= DB'(VB'(n_c_hi) - r_b_v);
            // A flat segment divides by one with a zero step, so its quotient is zero.
            r_c_den  <= (n_c_den == '0) ? DB'(1) : n_c_den;
            r_c_dk   <= n_c_dk;
        end
    end

    // Stage D: numerator and divisor of the rounded quotient.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res  <= r_c_res;
            o_num  <= ((NB'(r_c_dk) * NB'(r_c_diff)) << 1) + NB'(r_c_den);
            o_den2 <= {r_c_den, 1'b0};
        end
    end
endmodule
`default_nettype wire

@@ sv/dtl_div_stage.sv @@
`default_nettype none
module dtl_div_stage import dtl_pkg::*; #(
    parameter int NB    = 28,
    parameter int DB    = 21,
    parameter int SHIFT = 0
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_vld,
    input  t_res                    i_res,
    input  wire logic [NB-1:0]      i_rem,
    input  wire logic [DB:0]        i_den2,
    input  wire logic [Q_BITS-1:0]  i_q,
    output logic                    o_vld,
    output t_res                    o_res,
    output logic [NB-1:0]           o_rem,
    output logic [DB:0]             o_den2,
    output logic [Q_BITS-1:0]       o_q
);
    logic [NB-1:0]     n_trial, n_rem;
    logic [Q_BITS-1:0] n_q;

    always_comb begin
        n_trial = NB'(i_den2) << SHIFT;
        n_rem   = i_rem;
        n_q     = i_q;
        if (i_rem >= n_trial) begin
            n_rem      = i_rem - n_trial;
            n_q[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res  <= i_res;
            o_rem  <= n_rem;
            o_den2 <= i_den2;
            o_q    <= n_q;
        end
    end
endmodule
`default_nettype wire

@@ sv/diode_temperature_linearizer.sv @@
// Throughput: one request per cycle unless a valid output is stalled; 4 front
// stages, an 8-stage quotient pipeline one bit per stage, and the output register.
// The whole pipeline holds while a valid output is stalled.
// Reset (synchronous, active low) clears all valid bits; data is not reset.
`default_nettype none
`include "assert_macros.svh"
module diode_temperature_linearizer import dtl_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [SAMPLE_BITS-1:0]  i_sample_code,
    input  wire logic                    i_sample_valid,
    input  wire logic                    i_want_voltage,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [2:0]                   o_status,
    output logic [VALUE_BITS-1:0]        o_value
);
    localparam int DB = MV_BITS + SAMPLE_BITS;
    localparam int NB = DB + DK_BITS + 2;

    logic              w_en;
    logic              w_vld  [0:Q_BITS];
    t_res              w_res  [0:Q_BITS];
    logic [NB-1:0]     w_rem  [0:Q_BITS];
    logic [DB:0]       w_den2 [0:Q_BITS];
    logic [Q_BITS-1:0] w_q    [0:Q_BITS];
    logic              r_vld;
    t_res              r_res;

    assign w_en    = !(r_vld && i_stall);
    assign o_stall = !w_en;
    assign w_q[0]  = '0;

    dtl_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_vld          (i_valid),
        .i_code         (i_sample_code),
        .i_sample_valid (i_sample_valid),
        .i_want         (i_want_voltage),
        .o_vld          (w_vld[0]),
        .o_res          (w_res[0]),
        .o_num          (w_rem[0]),
        .o_den2         (w_den2[0])
    );

    for (genvar g = 0; g < Q_BITS; g++) begin : g_div
        dtl_div_stage #(
            .NB    (NB),
            .DB    (DB),
            .SHIFT (Q_BITS - 1 - g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_vld[g]),
            .i_res   (w_res[g]),
            .i_rem   (w_rem[g]),
            .i_den2  (w_den2[g]),
            .i_q     (w_q[g]),
            .o_vld   (w_vld[g+1]),
            .o_res   (w_res[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_den2  (w_den2[g+1]),
            .o_q     (w_q[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_en) begin
            r_vld <= w_vld[Q_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_res.status <= w_res[Q_BITS].status;
            if (w_res[Q_BITS].status == ST_TEMP) begin
                r_res.value <= w_res[Q_BITS].value + VALUE_BITS'(w_q[Q_BITS]);
            end else begin
                r_res.value <= w_res[Q_BITS].value;
            end
        end
    end

    assign o_valid  = r_vld;
    assign o_status = r_res.status;
    assign o_value  = r_res.value;

    `DTL_ASSERT(a_temp_range, i_clk, i_rst_n, (o_valid && o_status == ST_TEMP) |-> (o_value >= 12'd100 && o_value <= 12'd3500), "temperature out of table range")
    `DTL_ASSERT(a_flag_zero, i_clk, i_rst_n, (o_valid && (o_status == ST_INVALID || o_status == ST_OVER || o_status == ST_UNDER)) |-> (o_value == '0), "flagged result carries a value")
    `DTL_ASSERT(a_volt_range, i_clk, i_rst_n, (o_valid && o_status == ST_VOLT) |-> (o_value <= 12'd3000), "voltage above reference")
    `DTL_ASSERT(a_quot_range, i_clk, i_rst_n, (w_vld[Q_BITS] && w_res[Q_BITS].status == ST_TEMP) |-> (w_q[Q_BITS] <= Q_BITS'(100)), "interpolation step exceeds segment")
endmodule
`default_nettype wire

@@ tb/diode_temperature_linearizer_test.sv @@
`default_nettype none
module diode_temperature_linearizer_test;
    import dtl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM    = 650;
    localparam int WATCHDOG    = 20000;
    localparam int DRAIN_WAIT  = 40;

    typedef struct {
        logic [9:0] code;
        logic       sv;
        logic       wv;
        logic       known;
        t_status    st;
        logic [11:0] val;
    } t_row;

    typedef struct {
        t_status     st;
        logic [11:0] val;
    } t_reading;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [9:0]  i_sample_code = '0;
    logic        i_sample_valid = 1'b0;
    logic        i_want_voltage = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic [11:0] o_value;

    diode_temperature_linearizer i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_sample_code(i_sample_code), .i_sample_valid(i_sample_valid),
        .i_want_voltage(i_want_voltage),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_value(o_value)
    );

    always #5 i_clk = ~i_clk;

    t_reading pending_readings[$];
    int       mismatches = 0;
    int       idle_cycles = 0;
    bit       quiet_stretch = 1'b0;

    // Millivolt table of the thermometer, kept apart from the package.
    localparam int CAL_MV[35] = '{1420, 1214, 1107, 1088, 1071, 1053, 1034, 1015, 996,
        976, 955, 934, 912, 891, 869, 847, 824, 801, 779, 756, 732, 709, 686,
        662, 638, 615, 591, 567, 543, 519, 495, 471, 446, 422, 398};

    function automatic t_reading linearize(logic [9:0] code, logic sv, logic wv);
        t_reading r;
        longint   v, hi, lo, num, den;
        int       i;
        v = longint'(code) * 3000;
        r.val = '0;
        if (!sv) begin
            r.st = ST_INVALID;
        end else if (wv) begin
            r.st = ST_VOLT;
            r.val = 12'((v + 512) >> 10);
        end else if (v > (longint'(CAL_MV[0]) << 10)) begin
            r.st = ST_OVER;
        end else begin
            i = 1;
            while (i < 35 && v < (longint'(CAL_MV[i]) << 10)) i++;
            if (i >= 35) begin
                r.st = ST_UNDER;
            end else begin
                r.st = ST_TEMP;
                hi = longint'(CAL_MV[i-1]) << 10;
                lo = longint'(CAL_MV[i]) << 10;
                den = hi - lo;
                num = 100 * (hi - v);
                r.val = 12'(i * 100 + (2 * num + den) / (2 * den));
            end
        end
        return r;
    endfunction

    // Rows marked known carry a hand-worked answer; the rest go through the predictor.
    t_row directed_rows[] = '{
        '{10'd0,    1'b0, 1'b0, 1'b1, ST_INVALID, 12'd0},
        '{10'd1023, 1'b0, 1'b1, 1'b1, ST_INVALID, 12'd0},
        '{10'd0,    1'b1, 1'b1, 1'b1, ST_VOLT,    12'd0},
        '{10'd1023, 1'b1, 1'b1, 1'b1, ST_VOLT,    12'd2997},
        '{10'd512,  1'b1, 1'b1, 1'b1, ST_VOLT,    12'd1500},
        '{10'd1023, 1'b1, 1'b0, 1'b1, ST_OVER,    12'd0},
        '{10'd485,  1'b1, 1'b0, 1'b1, ST_OVER,    12'd0},
        '{10'd0,    1'b1, 1'b0, 1'b1, ST_UNDER,   12'd0},
        '{10'd135,  1'b1, 1'b0, 1'b1, ST_UNDER,   12'd0},
        '{10'd484,  1'b1, 1'b0, 1'b0, ST_TEMP,    12'd0},
        '{10'd136,  1'b1, 1'b0, 1'b0, ST_TEMP,    12'd0},
        '{10'd414,  1'b1, 1'b0, 1'b0, ST_TEMP,    12'd0},
        '{10'd300,  1'b1, 1'b0, 1'b0, ST_TEMP,    12'd0},
        '{10'd256,  1'b1, 1'b0, 1'b0, ST_TEMP,    12'd0},
        '{10'd375,  1'b1, 1'b0, 1'b0, ST_TEMP,    12'd0},
        '{10'd682,  1'b1, 1'b0, 1'b1, ST_OVER,    12'd0},
        '{10'd341,  1'b1, 1'b1, 1'b0, ST_VOLT,    12'd0}
    };

    function automatic bit idle_now();
        return !quiet_stretch && ($urandom_range(99) < 9);
    endfunction

    // Called at a falling edge; valid stays high after the accept until the
    // next request or an explicit idle replaces it.
    task automatic send_request(logic [9:0] code, logic sv, logic wv, t_reading want);
        while (idle_now()) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample_code <= code;
        i_sample_valid <= sv;
        i_want_voltage <= wv;
        do @(posedge i_clk); while (o_stall);
        pending_readings.push_back(want);
        @(negedge i_clk);
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result status=%0d value=%0d", o_status, o_value);
            end else begin
                t_reading w;
                w = pending_readings.pop_front();
                if (o_status !== w.st || o_value !== w.val) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("expected status=%0d value=%0d, got status=%0d value=%0d",
                                 w.st, w.val, o_status, o_value);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) i_stall <= idle_now();
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        t_reading want;
        logic [9:0] code;
        logic sv, wv;
        int kind, row;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (directed_rows[k]) begin
            if (directed_rows[k].known) begin
                want.st = directed_rows[k].st;
                want.val = directed_rows[k].val;
            end else begin
                want = linearize(directed_rows[k].code, directed_rows[k].sv,
                                 directed_rows[k].wv);
            end
            send_request(directed_rows[k].code, directed_rows[k].sv,
                         directed_rows[k].wv, want);
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            quiet_stretch = (n >= 200 && n < 300);
            if (n == 400) begin
                // Let the pipeline empty completely before carrying on.
                go_idle();
                while (pending_readings.size() != 0) @(negedge i_clk);
            end
            kind = $urandom_range(99);
            sv = (kind >= 8);
            wv = (kind >= 8 && kind < 25);
            if (kind < 75) begin
                // Most samples sit inside the table band, often right on a row.
                row = $urandom_range(34);
                code = 10'($urandom_range(136, 484));
                if ($urandom_range(3) == 0)
                    code = 10'((CAL_MV[row] * 1024 + 1500) / 3000);
            end else begin
                code = 10'($urandom);
            end
            send_request(code, sv, wv, linearize(code, sv, wv));
        end
        quiet_stretch = 1'b0;
        go_idle();
        while (pending_readings.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+sv
sv/dtl_pkg.sv
sv/dtl_front.sv
sv/dtl_div_stage.sv
sv/diode_temperature_linearizer.sv
tb/diode_temperature_linearizer_test.sv
